[rtl/gfd_pkg.sv]
package gfd_pkg;

    localparam int unsigned HUNT_LIMIT_DEF = 20;
    localparam int unsigned PAYLOAD_LEN    = 16;
    localparam int unsigned NUM_WORDS      = 6;
    localparam int unsigned POS_W          = 5;
    localparam int unsigned BTN_W          = 12;
    localparam int unsigned TDATA_OUT_W    = 120;

    localparam logic [7:0] HEADER_RST  = 8'hA5;
    localparam logic [7:0] TRAILER_RST = 8'hA6;

    localparam logic CFG_HEADER  = 1'b0;
    localparam logic CFG_TRAILER = 1'b1;

    typedef enum logic [1:0] {
        S_HUNT    = 2'b01,
        S_COLLECT = 2'b10
    } t_state;

    typedef logic [PAYLOAD_LEN-1:0][7:0] t_payload;

    typedef struct packed {
        logic fire;
        logic good;
    } t_evt;

    typedef struct packed {
        logic [BTN_W-1:0]                buttons;
        logic [7:0]                      combination;
        logic [NUM_WORDS-1:0][15:0]      words;
    } t_pad;

    typedef struct packed {
        logic err;
        t_pad pad;
    } t_result;

    function automatic logic [BTN_W-1:0] map_buttons(
        input logic [7:0] b14,
        input logic [7:0] b15,
        input logic [7:0] b16
    );
        map_buttons = {b16[0], b15[6], b15[5], b15[4], b15[3], b15[2],
                       b14[7], b14[6], b14[4], b14[3], b14[1], b14[0]};
    endfunction

endpackage

[rtl/gfd_deframe.sv]
module gfd_deframe #(
    parameter int unsigned HUNT_LIMIT = gfd_pkg::HUNT_LIMIT_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_addr,
    input  logic [7:0]        i_cfg_wdata,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [7:0]        i_s_tdata,
    input  logic              i_slot_free,
    output gfd_pkg::t_evt     o_evt,
    output gfd_pkg::t_payload o_payload
);

    localparam int unsigned CNT_W = $clog2(HUNT_LIMIT + 1);

    logic                  r_in_valid;
    logic [7:0]            r_in_byte;
    logic [7:0]            r_header;
    logic [7:0]            r_trailer;
    gfd_pkg::t_state       r_state;
    gfd_pkg::t_state       n_state;
    logic [gfd_pkg::POS_W-1:0] r_pos;
    logic [gfd_pkg::POS_W-1:0] n_pos;
    logic [CNT_W-1:0]      r_hunt;
    logic [CNT_W-1:0]      n_hunt;
    gfd_pkg::t_payload     r_payload;
    logic                  w_proc;
    logic                  w_store;
    gfd_pkg::t_evt         w_evt;

    assign o_s_tready = !r_in_valid || i_slot_free;
    assign w_proc     = r_in_valid && i_slot_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header  <= gfd_pkg::HEADER_RST;
            r_trailer <= gfd_pkg::TRAILER_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                gfd_pkg::CFG_HEADER:  r_header  <= i_cfg_wdata;
                gfd_pkg::CFG_TRAILER: r_trailer <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        n_pos   = r_pos;
        n_hunt  = r_hunt;
        w_evt   = '0;
        w_store = 1'b0;
        if (w_proc) begin
            case (r_state)
                gfd_pkg::S_HUNT: begin
                    if (r_in_byte == r_header) begin
                        n_state = gfd_pkg::S_COLLECT;
                        n_pos   = '0;
                        n_hunt  = '0;
                    end else if (r_hunt >= CNT_W'(HUNT_LIMIT)) begin
                        n_hunt     = '0;
                        w_evt.fire = 1'b1;
                    end else begin
                        n_hunt = r_hunt + CNT_W'(1);
                    end
                end
                gfd_pkg::S_COLLECT: begin
                    if (r_pos < gfd_pkg::POS_W'(gfd_pkg::PAYLOAD_LEN)) begin
                        w_store = 1'b1;
                        n_pos   = r_pos + gfd_pkg::POS_W'(1);
                    end else begin
                        n_state    = gfd_pkg::S_HUNT;
                        n_pos      = '0;
                        n_hunt     = '0;
                        w_evt.fire = 1'b1;
                        w_evt.good = (r_in_byte == r_trailer);
                    end
                end
                default: begin
                    n_state = gfd_pkg::S_HUNT;
                    n_pos   = '0;
                    n_hunt  = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gfd_pkg::S_HUNT;
            r_pos   <= '0;
            r_hunt  <= '0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_hunt  <= n_hunt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_store) begin
            r_payload[r_pos[gfd_pkg::POS_W-2:0]] <= r_in_byte;
        end
    end

    assign o_evt     = w_evt;
    assign o_payload = r_payload;

endmodule

[rtl/gfd_unpack.sv]
module gfd_unpack (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  gfd_pkg::t_evt     i_evt,
    input  gfd_pkg::t_payload i_payload,
    input  logic              i_m_tready,
    output logic              o_slot_free,
    output logic              o_valid,
    output gfd_pkg::t_result  o_result
);

    gfd_pkg::t_pad    w_unp;
    gfd_pkg::t_pad    r_held;
    gfd_pkg::t_result r_out;
    logic             r_out_valid;

    always_comb begin
        for (int k = 0; k < gfd_pkg::NUM_WORDS; k++) begin
            w_unp.words[k] = {i_payload[2*k+1], i_payload[2*k]};
        end
        w_unp.combination = i_payload[12];
        w_unp.buttons     = gfd_pkg::map_buttons(i_payload[13], i_payload[14],
                                                 i_payload[15]);
    end

    assign o_slot_free = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_held      <= '0;
        end else begin
            if (o_slot_free) begin
                r_out_valid <= i_evt.fire;
            end
            if (i_evt.fire && i_evt.good) begin
                r_held <= w_unp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_evt.fire) begin
            if (i_evt.good) begin
                r_out <= '{err: 1'b0, pad: w_unp};
            end else begin
                r_out <= '{err: 1'b1, pad: r_held};
            end
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

[rtl/gamepad_frame_deframer_unit.sv]
// Serial gamepad frame deframer. Each input transfer carries one received byte. While
// hunting, the block waits for the header byte and emits an error result (tuser high)
// after more than HUNT_LIMIT other bytes in a row. After a header it stores 16 payload
// bytes and checks the next byte against the trailer; a match emits the unpacked axes,
// triggers, combination byte and buttons, which are also held, and a mismatch emits an
// error carrying the values held from the last good frame. Every byte passes through an
// input register and the control logic, and a result sits in the output register, so one
// byte is taken per clock while the output side is not stalled. The user must write header
// and trailer values through the configuration port only while the block is idle; the
// block itself does not enforce this.
module gamepad_frame_deframer_unit #(
    parameter int unsigned HUNT_LIMIT = gfd_pkg::HUNT_LIMIT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic                            i_cfg_addr,
    input  logic [7:0]                      i_cfg_wdata,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // Fields from bit 0: rx_byte[7:0].
    input  logic [7:0]                      s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // Fields from bit 0: left_horizontal, left_vertical, right_horizontal,
    // right_vertical, left_trigger, right_trigger (16 bits each), combination (8),
    // buttons (12), zero fill (4).
    output logic [gfd_pkg::TDATA_OUT_W-1:0] m_axis_tdata,
    // Fields from bit 0: frame_error.
    output logic                            m_axis_tuser
);

    gfd_pkg::t_evt     w_evt;
    gfd_pkg::t_payload w_payload;
    gfd_pkg::t_result  w_result;
    logic              w_slot_free;

    gfd_deframe #(
        .HUNT_LIMIT (HUNT_LIMIT)
    ) u_deframe (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (s_axis_tvalid),
        .o_s_tready  (s_axis_tready),
        .i_s_tdata   (s_axis_tdata),
        .i_slot_free (w_slot_free),
        .o_evt       (w_evt),
        .o_payload   (w_payload)
    );

    gfd_unpack u_unpack (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_evt       (w_evt),
        .i_payload   (w_payload),
        .i_m_tready  (m_axis_tready),
        .o_slot_free (w_slot_free),
        .o_valid     (m_axis_tvalid),
        .o_result    (w_result)
    );

    assign m_axis_tdata = {{(gfd_pkg::TDATA_OUT_W - $bits(gfd_pkg::t_pad)){1'b0}},
                           w_result.pad};
    assign m_axis_tuser = w_result.err;

    a_fire_has_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_evt.fire |-> w_slot_free)
        else $error("result produced while the output register is occupied");

    a_good_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_evt.fire && w_evt.good) |=> (m_axis_tvalid && !m_axis_tuser))
        else $error("good frame did not give an error-free result");

    a_stall_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled without a pending result");

endmodule

[tb/sv/tb_top.sv]
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned HUNT_SPAN  = gfd_pkg::HUNT_LIMIT_DEF;
    localparam int          QUIET_LIMIT = 2000;
    localparam int          HOLD_CYCLES = 300;

    logic         i_clk = 1'b0;
    logic         i_rst_n;
    logic         i_cfg_we;
    logic         i_cfg_addr;
    logic [7:0]   i_cfg_wdata;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [gfd_pkg::TDATA_OUT_W-1:0] m_axis_tdata;
    logic         m_axis_tuser;

    gamepad_frame_deframer_unit #(
        .HUNT_LIMIT(HUNT_SPAN)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    // Deframer state as the checker sees it.
    logic [7:0]  hdr_val = gfd_pkg::HEADER_RST;
    logic [7:0]  trl_val = gfd_pkg::TRAILER_RST;
    logic        in_frame = 1'b0;
    int unsigned frame_pos = 0;
    int unsigned hunt_run = 0;
    logic [7:0]  frame_buf [gfd_pkg::PAYLOAD_LEN];
    gfd_pkg::t_pad    held_pad = '0;
    gfd_pkg::t_result pending_reports [$];

    bit tx_stalls = 1'b0;
    bit rx_stalls = 1'b0;
    int hold_request = 0;

    int mismatches = 0;
    int bytes_sent = 0;
    int frames_good = 0;
    int frames_bad = 0;
    int hunt_timeouts = 0;
    int reports_seen = 0;

    function automatic void unpack_frame();
        logic [7:0] b14;
        logic [7:0] b15;
        logic [7:0] b16;
        b14 = frame_buf[13];
        b15 = frame_buf[14];
        b16 = frame_buf[15];
        for (int k = 0; k < gfd_pkg::NUM_WORDS; k++) begin
            held_pad.words[k] = {frame_buf[2*k+1], frame_buf[2*k]};
        end
        held_pad.combination = frame_buf[12];
        held_pad.buttons[0]  = (b14 & 8'h01) != 0;
        held_pad.buttons[1]  = (b14 & 8'h02) != 0;
        held_pad.buttons[2]  = (b14 & 8'h08) != 0;
        held_pad.buttons[3]  = (b14 & 8'h10) != 0;
        held_pad.buttons[4]  = (b14 & 8'h40) != 0;
        held_pad.buttons[5]  = (b14 & 8'h80) != 0;
        held_pad.buttons[6]  = (b15 & 8'h04) != 0;
        held_pad.buttons[7]  = (b15 & 8'h08) != 0;
        held_pad.buttons[8]  = (b15 & 8'h10) != 0;
        held_pad.buttons[9]  = (b15 & 8'h20) != 0;
        held_pad.buttons[10] = (b15 & 8'h40) != 0;
        held_pad.buttons[11] = (b16 & 8'h01) != 0;
    endfunction

    function automatic void push_report(input logic err);
        gfd_pkg::t_result r;
        r.err = err;
        r.pad = held_pad;
        pending_reports.push_back(r);
    endfunction

    function automatic void deframe_predict(input logic [7:0] b);
        if (!in_frame) begin
            if (b == hdr_val) begin
                in_frame  = 1'b1;
                frame_pos = 0;
                hunt_run  = 0;
            end else if (hunt_run + 1 > HUNT_SPAN) begin
                hunt_run = 0;
                hunt_timeouts++;
                push_report(1'b1);
            end else begin
                hunt_run++;
            end
        end else if (frame_pos < gfd_pkg::PAYLOAD_LEN) begin
            frame_buf[frame_pos] = b;
            frame_pos++;
        end else begin
            in_frame  = 1'b0;
            frame_pos = 0;
            hunt_run  = 0;
            if (b == trl_val) begin
                unpack_frame();
                frames_good++;
                push_report(1'b0);
            end else begin
                frames_bad++;
                push_report(1'b1);
            end
        end
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 9);
        if (r < 8) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic int tx_gap();
        if (!tx_stalls || $urandom_range(0, 9) < 6) begin
            return 0;
        end
        return pick_gap();
    endfunction

    function automatic logic [7:0] other_than(input logic [7:0] avoid);
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (b == avoid);
        return b;
    endfunction

    function automatic logic [7:0] payload_byte();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0) begin
            return 8'h00;
        end else if (r == 1) begin
            return 8'hFF;
        end else if (r == 2) begin
            return hdr_val;
        end
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic void note_mismatch(input string what, input logic [15:0] want,
                                          input logic [15:0] got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("Mismatch in %s: expected %h, got %h.", what, want, got);
        end
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = tx_gap();
        repeat (gap) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge i_clk); while (!s_axis_tready);
        bytes_sent++;
        deframe_predict(b);
    endtask

    task automatic send_frame(input bit good_trailer);
        send_byte(hdr_val);
        repeat (gfd_pkg::PAYLOAD_LEN) send_byte(payload_byte());
        send_byte(good_trailer ? trl_val : other_than(trl_val));
    endtask

    task automatic send_hunt_run(input int n);
        repeat (n) send_byte(other_than(hdr_val));
    endtask

    task automatic settle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic addr, input logic [7:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (addr == gfd_pkg::CFG_HEADER) begin
            hdr_val = val;
        end else begin
            trl_val = val;
        end
    endtask

    task automatic test_directed_frames();
        tx_stalls = 1'b0;
        rx_stalls = 1'b0;
        send_byte(hdr_val);
        for (int k = 0; k < gfd_pkg::PAYLOAD_LEN; k++) begin
            send_byte(k == 12 ? hdr_val : 8'hFF);
        end
        send_byte(trl_val);
        send_byte(hdr_val);
        repeat (gfd_pkg::PAYLOAD_LEN) send_byte(8'h00);
        send_byte(other_than(trl_val));
        settle();
    endtask

    task automatic test_register_settings();
        logic [7:0] hdr_set [4];
        logic [7:0] trl_set [4];
        hdr_set = '{8'h00, 8'hFF, 8'h3C, 8'h00};
        trl_set = '{8'hFF, 8'h00, 8'h3C, 8'h00};
        hdr_set[3] = 8'($urandom_range(0, 255));
        trl_set[3] = 8'($urandom_range(0, 255));
        tx_stalls = 1'b1;
        rx_stalls = 1'b1;
        for (int p = 0; p < 4; p++) begin
            cfg_write(gfd_pkg::CFG_HEADER, hdr_set[p]);
            cfg_write(gfd_pkg::CFG_TRAILER, trl_set[p]);
            repeat (6) send_frame($urandom_range(0, 5) != 0);
            send_hunt_run($urandom_range(18, 45));
            send_frame(1'b1);
            settle();
        end
        cfg_write(gfd_pkg::CFG_HEADER, gfd_pkg::HEADER_RST);
        cfg_write(gfd_pkg::CFG_TRAILER, gfd_pkg::TRAILER_RST);
    endtask

    task automatic test_random_streams(input int target);
        int kind;
        int stop_at;
        stop_at = bytes_sent + target;
        while (bytes_sent < stop_at) begin
            kind = $urandom_range(0, 19);
            if (kind < 14) begin
                send_frame($urandom_range(0, 6) != 0);
            end else if (kind < 16) begin
                repeat ($urandom_range(1, 10)) send_byte(8'($urandom_range(0, 255)));
            end else if (kind < 18) begin
                send_hunt_run($urandom_range(15, 30));
            end else if (kind == 18) begin
                send_byte(hdr_val);
                repeat ($urandom_range(0, 15)) send_byte(payload_byte());
            end else begin
                tx_stalls = 1'($urandom_range(0, 1));
                rx_stalls = 1'($urandom_range(0, 1));
            end
        end
        settle();
    endtask

    task automatic test_output_backpressure();
        tx_stalls = 1'b0;
        rx_stalls = 1'b0;
        @(posedge i_clk);
        hold_request = HOLD_CYCLES;
        repeat (5) send_frame($urandom_range(0, 3) != 0);
        settle();
    endtask

    initial begin
        int n;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request != 0) begin
                n = hold_request;
                hold_request = 0;
                m_axis_tready <= 1'b0;
                repeat (n - 1) @(negedge i_clk);
            end else if (rx_stalls && $urandom_range(0, 3) == 0) begin
                n = pick_gap();
                m_axis_tready <= 1'b0;
                repeat (n - 1) @(negedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    gfd_pkg::t_result want;

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            reports_seen++;
            if (pending_reports.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("Result transfer with nothing expected: tuser %b, tdata %h.",
                             m_axis_tuser, m_axis_tdata);
                end
            end else begin
                want = pending_reports.pop_front();
                for (int k = 0; k < gfd_pkg::NUM_WORDS; k++) begin
                    if (m_axis_tdata[16*k +: 16] !== want.pad.words[k]) begin
                        note_mismatch($sformatf("axis word %0d", k), want.pad.words[k],
                                      m_axis_tdata[16*k +: 16]);
                    end
                end
                if (m_axis_tdata[96 +: 8] !== want.pad.combination) begin
                    note_mismatch("combination", 16'(want.pad.combination),
                                  16'(m_axis_tdata[96 +: 8]));
                end
                if (m_axis_tdata[104 +: gfd_pkg::BTN_W] !== want.pad.buttons) begin
                    note_mismatch("buttons", 16'(want.pad.buttons),
                                  16'(m_axis_tdata[104 +: gfd_pkg::BTN_W]));
                end
                if (m_axis_tdata[119:116] !== 4'h0) begin
                    note_mismatch("zero fill", 16'h0, 16'(m_axis_tdata[119:116]));
                end
                if (m_axis_tuser !== want.err) begin
                    note_mismatch("frame_error", 16'(want.err), 16'(m_axis_tuser));
                end
            end
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("Timeout: no transfer for %0d cycles.", QUIET_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_addr    = gfd_pkg::CFG_HEADER;
        i_cfg_wdata   = 8'h00;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_frames();
        test_register_settings();
        test_random_streams(650);
        test_output_backpressure();
        settle();

        $display("Sent %0d bytes: %0d good frames, %0d trailer errors, %0d hunt timeouts.",
                 bytes_sent, frames_good, frames_bad, hunt_timeouts);
        $display("Header and trailer set to extremes, equal and random; output held %0d cycles.",
                 HOLD_CYCLES);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("%0d mismatches in %0d results.", mismatches, reports_seen);
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
